### rtl/core/farc_pkg.sv
// Package for the fraction add and reduce block: widths, payload types and state codes.
package farc_pkg;

  // Input field width and the fixed result widths.
  localparam int unsigned InWidth  = 16;
  localparam int unsigned NumWidth = 33;
  localparam int unsigned DenWidth = 32;

  // Magnitudes of the unreduced sum and product fit in this many bits.
  localparam int unsigned MagWidth = 2 * InWidth;
  localparam int unsigned CntWidth = $clog2(MagWidth);

  // One input beat: two fractions.
  typedef struct packed {
    logic signed [InWidth-1:0] num_a;
    logic signed [InWidth-1:0] den_a;
    logic signed [InWidth-1:0] num_b;
    logic signed [InWidth-1:0] den_b;
  } farc_in_t;

  // One output beat: the reduced sum and the error flag.
  typedef struct packed {
    logic signed [NumWidth-1:0] sum_num;
    logic signed [DenWidth-1:0] sum_den;
    logic                       den_zero_error;
  } farc_out_t;

  // Status from the arithmetic engine to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } farc_stat_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL0  = 9'b000000010,
    ST_MUL1  = 9'b000000100,
    ST_MUL2  = 9'b000001000,
    ST_MUL3  = 9'b000010000,
    ST_GCD   = 9'b000100000,
    ST_DIV_N = 9'b001000000,
    ST_DIV_D = 9'b010000000,
    ST_DONE  = 9'b100000000
  } farc_state_e;

endpackage

### rtl/core/fraction_add_reduce_top.sv
// Top level of the fraction add and reduce block: handshake, output register and checks.

// Adds num_a/den_a and num_b/den_b and returns the sum reduced by the GCD of the
// magnitudes of its numerator and denominator, signs as the division leaves them;
// a zero input denominator returns 0/0 with den_zero_error set. The block works on
// one beat at a time and takes a new input beat only when its engine is idle. An
// item passes through the multiplier steps, the binary GCD loop at one step per
// cycle, two restoring divisions sharing the GCD subtractor, and handoff; a zero
// denominator skips the arithmetic and goes straight to handoff. A finished
// result sits in an output register, so the next input beat can be taken while
// it waits.
module fraction_add_reduce_top
  import farc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  farc_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output farc_out_t out_o
);

  farc_stat_t stat;
  farc_out_t  res;
  farc_out_t  out_q;
  logic       out_valid_q;
  logic       in_fire, res_take;

  assign in_ready_o = !stat.busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_take   = stat.done && (!out_valid_q || out_ready_i);

  farc_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .op_i    (in_i),
    .take_i  (res_take),
    .stat_o  (stat),
    .res_o   (res)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // An accepted beat makes the engine busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("engine did not start on an accepted beat");

  // A result handed over shows up as a valid output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> (out_valid_o && !stat.done))
    else $error("result handoff lost");

  // An error beat carries zero results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.den_zero_error) |-> (out_o.sum_num == '0 && out_o.sum_den == '0))
    else $error("error beat with nonzero results");

  // A valid sum never has a zero denominator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.den_zero_error) |-> (out_o.sum_den != '0))
    else $error("zero denominator in a valid sum");

endmodule

### rtl/core/farc_engine.sv
// Sequenced engine: shared multiplier, binary GCD and restoring divider on one subtractor.
module farc_engine
  import farc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  farc_in_t   op_i,
  input  logic       take_i,
  output farc_stat_t stat_o,
  output farc_out_t  res_o
);

  localparam logic [CntWidth-1:0] DivLast = CntWidth'(MagWidth - 1);

  farc_state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  // Datapath registers.
  farc_in_t                   op_q;
  logic signed [MagWidth-1:0] prod_q;
  logic signed [NumWidth-1:0] n_q;
  logic [MagWidth-1:0]        nm_q, qm_q;
  logic [MagWidth-1:0]        u_q, v_q, g_q;
  logic [MagWidth-1:0]        rem_q, quo_q;
  logic [CntWidth-1:0]        k_q;
  logic                       sign_n_q, sign_q_q, err_q;

  logic signed [InWidth-1:0]  mul_a, mul_b;
  logic signed [MagWidth-1:0] mul_p;
  logic [NumWidth-1:0]        n_neg;
  logic [MagWidth-1:0]        prod_neg;
  logic [MagWidth:0]          rem_sh;
  logic [MagWidth:0]          sub_x, sub_y;
  logic [MagWidth+1:0]        sub_r;
  logic                       sub_borrow;
  logic [MagWidth-1:0]        quo_next;
  logic                       gcd_end, den_zero;
  logic [NumWidth-1:0]        nm_ext;

  // Shared multiplier: one product per cycle, registered.
  always_comb begin
    case (state_q)
      ST_MUL0: begin
        mul_a = op_q.num_a;
        mul_b = op_q.den_b;
      end
      ST_MUL1: begin
        mul_a = op_q.num_b;
        mul_b = op_q.den_a;
      end
      default: begin
        mul_a = op_q.den_a;
        mul_b = op_q.den_b;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Magnitudes of the sum and the denominator product.
  assign n_neg    = NumWidth'(-n_q);
  assign prod_neg = MagWidth'(-prod_q);

  // Shared subtractor: u - v during GCD, trial subtraction during division.
  assign rem_sh     = {rem_q, quo_q[MagWidth-1]};
  assign sub_x      = (state_q == ST_GCD) ? {1'b0, u_q} : rem_sh;
  assign sub_y      = (state_q == ST_GCD) ? {1'b0, v_q} : {1'b0, g_q};
  assign sub_r      = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_borrow = sub_r[MagWidth+1];
  assign quo_next   = {quo_q[MagWidth-2:0], ~sub_borrow};

  assign gcd_end  = (u_q == '0) || (v_q == '0);
  assign den_zero = (op_i.den_a == '0) || (op_i.den_b == '0);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = den_zero ? ST_DONE : ST_MUL0;
        end
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_GCD;
      ST_GCD: begin
        if (gcd_end) begin
          state_d = ST_DIV_N;
          cnt_d   = '0;
        end
      end
      ST_DIV_N: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_DIV_D;
          cnt_d   = '0;
        end
      end
      ST_DIV_D: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath updates per state.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_q     <= op_i;
          err_q    <= den_zero;
          nm_q     <= '0;
          qm_q     <= '0;
          sign_n_q <= 1'b0;
          sign_q_q <= 1'b0;
        end
      end
      ST_MUL1: n_q <= {prod_q[MagWidth-1], prod_q};
      ST_MUL2: n_q <= n_q + {prod_q[MagWidth-1], prod_q};
      ST_MUL3: begin
        sign_n_q <= n_q[NumWidth-1];
        sign_q_q <= prod_q[MagWidth-1];
        nm_q     <= n_q[NumWidth-1] ? n_neg[MagWidth-1:0] : n_q[MagWidth-1:0];
        qm_q     <= prod_q[MagWidth-1] ? prod_neg : prod_q;
        u_q      <= n_q[NumWidth-1] ? n_neg[MagWidth-1:0] : n_q[MagWidth-1:0];
        v_q      <= prod_q[MagWidth-1] ? prod_neg : prod_q;
        k_q      <= '0;
      end
      ST_GCD: begin
        // Binary GCD: strip common twos, strip lone twos, swap or subtract odd values.
        if (gcd_end) begin
          g_q   <= (u_q | v_q) << k_q;
          rem_q <= '0;
          quo_q <= nm_q;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (sub_borrow) begin
          u_q <= v_q;
          v_q <= u_q;
        end else begin
          u_q <= sub_r[MagWidth-1:0];
        end
      end
      ST_DIV_N, ST_DIV_D: begin
        // One quotient bit per cycle; the last numerator bit hands over to the denominator.
        if ((cnt_q == DivLast) && (state_q == ST_DIV_N)) begin
          nm_q  <= quo_next;
          rem_q <= '0;
          quo_q <= qm_q;
        end else begin
          rem_q <= sub_borrow ? rem_sh[MagWidth-1:0] : sub_r[MagWidth-1:0];
          quo_q <= quo_next;
          if (cnt_q == DivLast) begin
            qm_q <= quo_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result with the signs restored.
  assign nm_ext = {1'b0, nm_q};
  always_comb begin
    res_o.sum_num        = $signed(sign_n_q ? NumWidth'(-nm_ext) : nm_ext);
    res_o.sum_den        = $signed(sign_q_q ? DenWidth'(-qm_q) : DenWidth'(qm_q));
    res_o.den_zero_error = err_q;
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);

endmodule
